/* hw/rtl/bts_pkg.sv */
// Package for the bilinear texture sampler: item structs, register indexes
// and fixed-point format constants. No dependencies.
`default_nettype none

package bts_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int WEIGHT_BITS     = 8;
  localparam int WEIGHT_ONE      = 1 << WEIGHT_BITS;
  localparam int CHANNELS        = 3;
  localparam int CFG_W           = 9;
  localparam int CFG_INDEX_W     = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]       DIM_RESET  = 9'd256;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [15:0] CHANNEL_MAX = 16'hFF00;

  typedef logic [CHANNELS-1:0][7:0] texel_t;

  typedef struct packed {
    logic        func;
    logic [15:0] s_coord;
    logic [15:0] t_coord;
    logic [7:0]  texel_column;
    logic [7:0]  texel_row;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic [7:0]  texel_blue;
  } req_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/bts_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bilinear_texture_sampler.sv */
// Top level of the bilinear texture sampler with repeat wrap.
// Depends on bts_pkg and bts_ram.
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+---------------------------------
//   req      | req_valid, req_stall, req        | texel write or sample item
//   rsp      | rsp_valid, rsp_stall, rsp        | filtered RGB result item
//   cfg      | cfg_write_en, cfg_index, cfg_data| texture width and height
//
// One item enters per cycle while req_stall is low; a sample's result passes
// through the five register stages (multiply, wrap, texel read, horizontal
// blend, vertical blend). Writes give no result.
// Reset is synchronous; it empties the pipeline and sets both dimensions to 256.
// Each stage holds only while the stage after it is full and held, so a
// stall on rsp backs up through the pipeline one bubble at a time.
`default_nettype none

module bilinear_texture_sampler #(
  parameter int MAX_DIM = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire bts_pkg::req_t                     req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output bts_pkg::rsp_t                          rsp,
  input  wire logic                              cfg_write_en,
  input  wire logic [bts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bts_pkg::CFG_W-1:0]         cfg_data
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int F     = bts_pkg::COORD_FRAC_BITS;
  localparam int WB    = bts_pkg::WEIGHT_BITS;
  localparam int PW    = F + DW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = 8 * bts_pkg::CHANNELS;

  localparam logic [PW-1:0] HALF       = PW'(1) << (F - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);

  typedef struct packed {
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic [WB-1:0] w;
  } axis_t;

  function automatic logic [DW-1:0] clamp_dim(input logic [bts_pkg::CFG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  function automatic axis_t axis_calc(input logic [PW-1:0] p, input logic [DW-1:0] dim);
    logic [PW-1:0] diff;
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
    axis_t         r;
    diff = p - HALF;
    if (p < HALF) begin
      lo = dim - DW'(1);
    end else begin
      lo = diff[PW-1:F];
    end
    hi = ((lo + DW'(1)) == dim) ? '0 : lo + DW'(1);
    r.lo = IW'(lo);
    r.hi = IW'(hi);
    r.w  = diff[F-1:F-WB];
    return r;
  endfunction

  function automatic logic [AW-1:0] texel_addr(input logic [IW-1:0] col,
                                               input logic [IW-1:0] row);
    return AW'(AW'(row) * ROW_STRIDE + AW'(col));
  endfunction

  function automatic logic [15:0] lerp_h(input logic [7:0] a, input logic [7:0] b,
                                         input logic [WB-1:0] w);
    logic [16:0] acc;
    acc = 17'(a) * (17'(bts_pkg::WEIGHT_ONE) - 17'(w)) + 17'(b) * 17'(w);
    return acc[15:0];
  endfunction

  function automatic logic [15:0] lerp_v(input logic [15:0] a, input logic [15:0] b,
                                         input logic [WB-1:0] w);
    logic [24:0] acc;
    acc = 25'(a) * (25'(bts_pkg::WEIGHT_ONE) - 25'(w)) + 25'(b) * 25'(w);
    return acc[23:8];
  endfunction

  logic [bts_pkg::CFG_W-1:0] tex_width;
  logic [bts_pkg::CFG_W-1:0] tex_height;
  logic [DW-1:0]             dim_w;
  logic [DW-1:0]             dim_h;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  bts_pkg::req_t in1;
  bts_pkg::req_t in2;
  logic [PW-1:0] ps1;
  logic [PW-1:0] pt1;
  axis_t         ax_s;
  axis_t         ax_t;
  axis_t         ax2;
  axis_t         ay2;
  logic [WB-1:0] wh3;
  logic [WB-1:0] wv3;
  logic [WB-1:0] wv4;
  logic [15:0]   top4 [bts_pkg::CHANNELS];
  logic [15:0]   bot4 [bts_pkg::CHANNELS];
  bts_pkg::rsp_t rsp_reg;

  bts_pkg::texel_t tl3, tr3, bl3, br3;
  bts_pkg::texel_t wr_texel;
  logic            ram_we;
  logic [AW-1:0]   wr_addr;

  assign dim_w = clamp_dim(tex_width);
  assign dim_h = clamp_dim(tex_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= bts_pkg::DIM_RESET;
      tex_height <= bts_pkg::DIM_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        bts_pkg::REG_WIDTH:  tex_width  <= cfg_data;
        bts_pkg::REG_HEIGHT: tex_height <= cfg_data;
      endcase
    end
  end

  assign rdy5 = !v5 || !rsp_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2 && (in2.func == bts_pkg::FUNC_SAMPLE);
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  assign ax_s = axis_calc(ps1, dim_w);
  assign ax_t = axis_calc(pt1, dim_h);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      in1 <= req;
      ps1 <= PW'(req.s_coord[F-1:0]) * PW'(dim_w);
      pt1 <= PW'(req.t_coord[F-1:0]) * PW'(dim_h);
    end
    if (rdy2) begin
      in2 <= in1;
      ax2 <= ax_s;
      ay2 <= ax_t;
    end
    if (rdy3) begin
      wh3 <= ax2.w;
      wv3 <= ay2.w;
    end
    if (rdy4) begin
      wv4 <= wv3;
      for (int c = 0; c < bts_pkg::CHANNELS; c++) begin
        top4[c] <= lerp_h(tl3[c], tr3[c], wh3);
        bot4[c] <= lerp_h(bl3[c], br3[c], wh3);
      end
    end
    if (rdy5) begin
      rsp_reg.red_out   <= lerp_v(top4[0], bot4[0], wv4);
      rsp_reg.green_out <= lerp_v(top4[1], bot4[1], wv4);
      rsp_reg.blue_out  <= lerp_v(top4[2], bot4[2], wv4);
    end
  end

  assign wr_texel = {in2.texel_blue, in2.texel_green, in2.texel_red};
  assign wr_addr  = AW'(AW'(in2.texel_row) * ROW_STRIDE + AW'(in2.texel_column));
  assign ram_we   = rdy3 && v2 && (in2.func == bts_pkg::FUNC_WRITE) &&
                    (32'(in2.texel_column) < MAX_DIM) && (32'(in2.texel_row) < MAX_DIM);

  bts_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_ram_top (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_addr),
    .wdata   (wr_texel),
    .re      (rdy3),
    .raddr_a (texel_addr(ax2.lo, ay2.lo)),
    .raddr_b (texel_addr(ax2.hi, ay2.lo)),
    .rdata_a (tl3),
    .rdata_b (tr3)
  );

  bts_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_ram_bot (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_addr),
    .wdata   (wr_texel),
    .re      (rdy3),
    .raddr_a (texel_addr(ax2.lo, ay2.hi)),
    .raddr_b (texel_addr(ax2.hi, ay2.hi)),
    .rdata_a (bl3),
    .rdata_b (br3)
  );

  assign rsp_valid = v5;
  assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* hw/rtl/bts_check.sv */
// Port-level checker for the bilinear texture sampler and its bind statement.
// Depends on bts_pkg and the top level bilinear_texture_sampler.
`default_nettype none

module bts_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire bts_pkg::rsp_t rsp
);

  a_rsp_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("Result item dropped while stalled.");

  a_rsp_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("Result item changed while stalled.");

  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.red_out <= bts_pkg::CHANNEL_MAX) &&
                  (rsp.green_out <= bts_pkg::CHANNEL_MAX) &&
                  (rsp.blue_out <= bts_pkg::CHANNEL_MAX))
    else $error("Filtered channel exceeds the largest blend of byte texels.");

  a_rsp_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("Result item shown right after reset.");

endmodule

bind bilinear_texture_sampler bts_check u_bts_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
